FILE: design/inverse_power_pair_force_assert.svh
// Assertion macros shared by the force pipeline.
`ifndef INVERSE_POWER_PAIR_FORCE_ASSERT_SVH
`define INVERSE_POWER_PAIR_FORCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IPPF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ippf: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IPPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ippf: assertion failed");

`endif

FILE: design/ippf_pkg.sv
// Shared types and constants of the pairwise force pipeline.
package ippf_pkg;

	localparam int W    = 32;   // field width
	localparam int DXW  = 33;   // coordinate difference / distance width
	localparam int DSQW = 66;   // squared distance width
	localparam int PW   = 3;    // distance power width

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_SCALE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_POWER = 1'd1;

	localparam logic [W-1:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

	// Per-request data carried through the square root stages
	typedef struct packed {
		logic            coin;
		logic            negx;
		logic            negy;
		logic [PW-1:0]   pwr;
		logic [DXW-1:0]  adx;
		logic [DXW-1:0]  ady;
		logic [2*W-1:0]  base1;
		logic [W-1:0]    q2m;
	} pre_t;

endpackage

FILE: design/ippf_mul.sv
// Two-stage unsigned multiplier built from partial products of 32-bit slices of a.
module ippf_mul #(
	parameter int AW = 64,
	parameter int BW = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             out_vld,
	output logic [AW+BW-1:0] p
);

	localparam int CW  = 32;
	localparam int NC  = (AW + CW - 1) / CW;
	localparam int PAD = NC * CW;

	logic [PAD-1:0]     a_pad;
	logic [CW+BW-1:0]   pp_s1 [NC];
	logic [AW+BW-1:0]   sum;
	logic [AW+BW-1:0]   prod_s2;
	logic               vld_s1;
	logic               vld_s2;

	assign a_pad = PAD'(a);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: one partial product per 32-bit slice of a
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				pp_s1[i] <= (CW+BW)'(a_pad[i*CW +: CW]) * (CW+BW)'(b);
			end
		end
	end

	// stage 2: align and add the slices
	always_comb begin
		sum = '0;
		for (int i = 0; i < NC; i++) begin
			sum = sum + ((AW+BW)'(pp_s1[i]) << (i * CW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= sum;
		end
	end

	assign out_vld = vld_s2;
	assign p       = prod_s2;

endmodule

FILE: design/ippf_div.sv
// Pipelined restoring divider: 32-bit quotient plus overflow flag, one bit a stage.
module ippf_div #(
	parameter int NW = 222,
	parameter int DW = 313,
	parameter int SW = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [NW-1:0]             num,
	input  logic [DW-1:0]             den,
	input  logic [SW-1:0]             side,
	output logic                      out_vld,
	output logic [ippf_pkg::W-1:0]    quo,
	output logic                      ovf,
	output logic [SW-1:0]             side_out
);

	localparam int QW = ippf_pkg::W;
	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [NW-1:0] rem_s  [QW+1];
	logic [DW-1:0] dn_s   [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic          ovf_s  [QW+1];
	logic [SW-1:0] sd_s   [QW+1];
	logic          vld_s  [QW+1];
	logic [CW-1:0] diff0;

	// entry: quotient of 2^32 or more saturates whatever its sign
	assign diff0 = CW'(num) - (CW'(den) << QW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			dn_s[0]  <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= ~diff0[CW-1];
			sd_s[0]  <= side;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QW; j++) begin : g_step
		localparam int B = QW - j;
		logic [CW-1:0] diff;
		logic          take;
		logic [QW-1:0] q_nxt;

		assign diff = CW'(rem_s[j-1]) - (CW'(dn_s[j-1]) << B);
		assign take = ~diff[CW-1];

		always_comb begin
			q_nxt    = q_s[j-1];
			q_nxt[B] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? diff[NW-1:0] : rem_s[j-1];
				dn_s[j]  <= dn_s[j-1];
				q_s[j]   <= q_nxt;
				ovf_s[j] <= ovf_s[j-1];
				sd_s[j]  <= sd_s[j-1];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = q_s[QW];
	assign ovf      = ovf_s[QW];
	assign side_out = sd_s[QW];

endmodule

FILE: design/inverse_power_pair_force.sv
// Inverse-power pairwise force between two bodies: top level with
// configuration registers, square root, power chain and output saturation.
//
// Takes one body pair per clock while the pipeline is not held and returns
// the force on the first body, scale*q1*q2/d^(p+1) along the unit vector
// from the second body to the first, in signed fixed point with FRAC_BITS
// fraction bits, saturated to 32 bits (clipped set) and forced to zero for
// coincident bodies. The pipeline holds four input and product stages, a
// 33-stage square root, P+1 multipliers with P = min(MAX_POWER, 7) that
// raise the distance to its power, a 33-stage divider and the output
// register. result_stall holds the whole pipeline while a result is valid
// and is passed back on item_stall. cfg_ready is always high;
// write registers only while no request is in flight.
module inverse_power_pair_force #(
	parameter int FRAC_BITS = 16,
	parameter int MAX_POWER = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [ippf_pkg::W-1:0]            first_x,
	input  logic [ippf_pkg::W-1:0]            first_y,
	input  logic [ippf_pkg::W-1:0]            second_x,
	input  logic [ippf_pkg::W-1:0]            second_y,
	input  logic [ippf_pkg::W-1:0]            first_charge,
	input  logic [ippf_pkg::W-1:0]            second_charge,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [ippf_pkg::W-1:0]            force_x,
	output logic [ippf_pkg::W-1:0]            force_y,
	output logic                              coincident,
	output logic                              clipped,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ippf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ippf_pkg::W-1:0]            cfg_data
);

	`include "inverse_power_pair_force_assert.svh"

	localparam int W     = ippf_pkg::W;
	localparam int DXW   = ippf_pkg::DXW;
	localparam int DSQW  = ippf_pkg::DSQW;
	localparam int PW    = ippf_pkg::PW;
	localparam int PMAX  = (MAX_POWER < 7) ? MAX_POWER : 7;
	localparam int SQ_N  = DXW;                        // root bits
	localparam int BW3   = 3 * W;                      // |S*Q1*Q2|
	localparam int BSW   = BW3 + FRAC_BITS * (PMAX - 1);
	localparam int NW    = BSW + DXW;
	localparam int ACC_W = DXW * (PMAX + 2);
	localparam int DEN_W = ACC_W + FRAC_BITS;

	typedef struct packed {
		logic            coin;
		logic            negx;
		logic            negy;
		logic [PW-1:0]   pwr;
		logic [DXW-1:0]  d;
		logic [NW-1:0]   nx;
		logic [NW-1:0]   ny;
	} chain_t;

	logic en;

	// configuration registers
	logic [W-1:0]  force_scale_q;
	logic [PW-1:0] distance_power_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_scale_q    <= 32'sd65536;
			distance_power_q <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ippf_pkg::REG_FORCE_SCALE:    force_scale_q    <= cfg_data;
				ippf_pkg::REG_DISTANCE_POWER: distance_power_q <= cfg_data[PW-1:0];
				default:                      force_scale_q    <= force_scale_q;
			endcase
		end
	end

	// global advance: the output register frees up or is taken
	logic res_vld_q;

	assign en         = !res_vld_q || !result_stall;
	assign item_stall = !en;

	// stage 1: capture request
	logic         vld_s1;
	logic [W-1:0] fx_s1, fy_s1, sx_s1, sy_s1, q1_s1, q2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= first_x;
			fy_s1 <= first_y;
			sx_s1 <= second_x;
			sy_s1 <= second_y;
			q1_s1 <= first_charge;
			q2_s1 <= second_charge;
		end
	end

	// stage 2: differences, magnitudes and signs
	logic [DXW-1:0] dx, dy;
	logic [PW-1:0]  pwr_c;
	logic           neg_c;

	assign dx    = {fx_s1[W-1], fx_s1} - {sx_s1[W-1], sx_s1};
	assign dy    = {fy_s1[W-1], fy_s1} - {sy_s1[W-1], sy_s1};
	assign pwr_c = (distance_power_q > PW'(PMAX)) ? PW'(PMAX) : distance_power_q;
	assign neg_c = force_scale_q[W-1] ^ q1_s1[W-1] ^ q2_s1[W-1];

	logic           vld_s2;
	logic [DXW-1:0] adx_s2, ady_s2;
	logic           coin_s2, negx_s2, negy_s2;
	logic [PW-1:0]  pwr_s2;
	logic [W-1:0]   ms_s2, mq1_s2, mq2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s2  <= dx[DXW-1] ? (~dx + DXW'(1)) : dx;
			ady_s2  <= dy[DXW-1] ? (~dy + DXW'(1)) : dy;
			coin_s2 <= (dx == '0) && (dy == '0);
			negx_s2 <= neg_c ^ dx[DXW-1];
			negy_s2 <= neg_c ^ dy[DXW-1];
			pwr_s2  <= pwr_c;
			ms_s2   <= force_scale_q[W-1] ? (~force_scale_q + W'(1)) : force_scale_q;
			mq1_s2  <= q1_s1[W-1] ? (~q1_s1 + W'(1)) : q1_s1;
			mq2_s2  <= q2_s1[W-1] ? (~q2_s1 + W'(1)) : q2_s1;
		end
	end

	// stage 3: squares of the differences, |S|*|Q1|
	logic            vld_s3;
	ippf_pkg::pre_t  pre_s3;
	logic [DSQW-1:0] dxsq_s3, dysq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxsq_s3      <= DSQW'(adx_s2) * DSQW'(adx_s2);
			dysq_s3      <= DSQW'(ady_s2) * DSQW'(ady_s2);
			pre_s3.coin  <= coin_s2;
			pre_s3.negx  <= negx_s2;
			pre_s3.negy  <= negy_s2;
			pre_s3.pwr   <= pwr_s2;
			pre_s3.adx   <= adx_s2;
			pre_s3.ady   <= ady_s2;
			pre_s3.base1 <= (2*W)'(ms_s2) * (2*W)'(mq1_s2);
			pre_s3.q2m   <= mq2_s2;
		end
	end

	// stage 4 and square root: entry 0 holds the squared distance
	logic [DSQW-1:0] sq_rem_s  [SQ_N+1];
	logic [DXW-1:0]  sq_root_s [SQ_N+1];
	ippf_pkg::pre_t  sq_pre_s  [SQ_N+1];
	logic            sq_vld_s  [SQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (en) begin
			sq_vld_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0]  <= dxsq_s3 + dysq_s3;
			sq_root_s[0] <= '0;
			sq_pre_s[0]  <= pre_s3;
		end
	end

	// one root bit per stage: keep rem = n - root^2
	for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
		localparam int B = SQ_N - j;
		logic [DSQW:0]   trial;
		logic [DSQW+1:0] diff;
		logic            take;

		assign trial = ((DSQW+1)'(sq_root_s[j-1]) << (B + 1)) | ((DSQW+1)'(1) << (2 * B));
		assign diff  = (DSQW+2)'(sq_rem_s[j-1]) - (DSQW+2)'(trial);
		assign take  = ~diff[DSQW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else if (en) begin
				sq_vld_s[j] <= sq_vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[j]  <= take ? diff[DSQW-1:0] : sq_rem_s[j-1];
				sq_root_s[j] <= sq_root_s[j-1] | (DXW'(take) << B);
				sq_pre_s[j]  <= sq_pre_s[j-1];
			end
		end
	end

	// power chain: acc = d^(k+1) entering step k, until it reaches d^(p+2)
	chain_t           cs   [PMAX+2];
	logic [ACC_W-1:0] acc  [PMAX+2];
	logic             cvld [PMAX+2];
	ippf_pkg::pre_t   pre_f;

	assign pre_f   = sq_pre_s[SQ_N];
	assign cs[0]   = '{coin: pre_f.coin, negx: pre_f.negx, negy: pre_f.negy,
	                   pwr: pre_f.pwr, d: sq_root_s[SQ_N],
	                   nx: NW'(pre_f.adx), ny: NW'(pre_f.ady)};
	assign acc[0]  = ACC_W'(sq_root_s[SQ_N]);
	assign cvld[0] = sq_vld_s[SQ_N];

	// |S*Q1*Q2| alongside the first power step
	logic [BW3-1:0] base;
	logic           base_vld;

	ippf_mul #(.AW(2*W), .BW(W)) u_base (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (cvld[0]),
		.a       (pre_f.base1),
		.b       (pre_f.q2m),
		.out_vld (base_vld),
		.p       (base)
	);

	for (genvar k = 0; k <= PMAX; k++) begin : g_pow
		localparam int AK = DXW * (k + 1);
		logic [DXW-1:0]    mb;
		logic [AK+DXW-1:0] pw_p;
		logic              pw_vld;
		chain_t            cs_a_s, cs_b_s;

		// multiply by d while the power is not yet reached, else by one
		assign mb = ((k == 0) || (PW'(k) <= cs[k].pwr)) ? cs[k].d : DXW'(1);

		ippf_mul #(.AW(AK), .BW(DXW)) u_pw (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (cvld[k]),
			.a       (acc[k][AK-1:0]),
			.b       (mb),
			.out_vld (pw_vld),
			.p       (pw_p)
		);

		always_ff @(posedge clk) begin
			if (en) begin
				cs_a_s <= cs[k];
				cs_b_s <= cs_a_s;
			end
		end

		assign acc[k+1] = ACC_W'(pw_p);

		if (k == 0) begin : g_first
			assign cs[k+1]   = cs_b_s;
			assign cvld[k+1] = pw_vld & base_vld;
		end else if (k == 1) begin : g_num
			// numerators: base scaled by 2^(F*(p-1)) (by one for p = 0), times |dx| and |dy|
			logic [BSW-1:0] base_sh;
			logic [NW-1:0]  nx_p, ny_p;
			logic           nx_vld, ny_vld;

			always_comb begin
				if (cs[k].pwr == '0) begin
					base_sh = BSW'(base);
				end else begin
					base_sh = BSW'(base) << (FRAC_BITS * (int'(cs[k].pwr) - 1));
				end
			end

			ippf_mul #(.AW(BSW), .BW(DXW)) u_nx (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.in_vld  (cvld[k]),
				.a       (base_sh),
				.b       (cs[k].nx[DXW-1:0]),
				.out_vld (nx_vld),
				.p       (nx_p)
			);

			ippf_mul #(.AW(BSW), .BW(DXW)) u_ny (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.in_vld  (cvld[k]),
				.a       (base_sh),
				.b       (cs[k].ny[DXW-1:0]),
				.out_vld (ny_vld),
				.p       (ny_p)
			);

			assign cs[k+1]   = '{coin: cs_b_s.coin, negx: cs_b_s.negx, negy: cs_b_s.negy,
			                     pwr: cs_b_s.pwr, d: cs_b_s.d, nx: nx_p, ny: ny_p};
			assign cvld[k+1] = pw_vld & nx_vld & ny_vld;
		end else begin : g_pass
			assign cs[k+1]   = cs_b_s;
			assign cvld[k+1] = pw_vld;
		end
	end

	// denominator: power zero carries an extra 2^F
	chain_t           cs_f;
	logic [DEN_W-1:0] den_f;

	assign cs_f  = cs[PMAX+1];
	assign den_f = (cs_f.pwr == '0) ? (DEN_W'(acc[PMAX+1]) << FRAC_BITS)
	                                : DEN_W'(acc[PMAX+1]);

	logic [W-1:0] qx, qy;
	logic         ovfx, ovfy, dvx_vld, dvy_vld;
	logic [1:0]   sdx;
	logic         sdy;

	ippf_div #(.NW(NW), .DW(DEN_W), .SW(2)) u_divx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (cvld[PMAX+1]),
		.num      (cs_f.nx),
		.den      (den_f),
		.side     ({cs_f.coin, cs_f.negx}),
		.out_vld  (dvx_vld),
		.quo      (qx),
		.ovf      (ovfx),
		.side_out (sdx)
	);

	ippf_div #(.NW(NW), .DW(DEN_W), .SW(1)) u_divy (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (cvld[PMAX+1]),
		.num      (cs_f.ny),
		.den      (den_f),
		.side     (cs_f.negy),
		.out_vld  (dvy_vld),
		.quo      (qy),
		.ovf      (ovfy),
		.side_out (sdy)
	);

	// apply sign and saturate; returns {clip, value}
	function automatic logic [W:0] sat_comp(input logic neg, input logic [W-1:0] q,
	                                        input logic ovf);
		logic         clip;
		logic [W-1:0] val;
		if (neg) begin
			clip = ovf | (q[W-1] & (|q[W-2:0]));
			val  = clip ? ippf_pkg::SAT_NEG : (~q + W'(1));
		end else begin
			clip = ovf | q[W-1];
			val  = clip ? ippf_pkg::SAT_POS : q;
		end
		return {clip, val};
	endfunction

	logic [W:0] rx, ry;

	assign rx = sat_comp(sdx[0], qx, ovfx);
	assign ry = sat_comp(sdy, qy, ovfy);

	// output register
	logic [W-1:0] fx_q, fy_q;
	logic         coin_q, clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= dvx_vld & dvy_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coin_q <= sdx[1];
			if (sdx[1]) begin
				fx_q   <= '0;
				fy_q   <= '0;
				clip_q <= 1'b0;
			end else begin
				fx_q   <= rx[W-1:0];
				fy_q   <= ry[W-1:0];
				clip_q <= rx[W] | ry[W];
			end
		end
	end

	assign result_valid = res_vld_q;
	assign force_x      = fx_q;
	assign force_y      = fy_q;
	assign coincident   = coin_q;
	assign clipped      = clip_q;

	// checks
	`IPPF_ASSERT_NOW(a_coin_zero, result_valid && coincident, force_x == '0 && force_y == '0 && !clipped)
	`IPPF_ASSERT_NOW(a_clip_sat, result_valid && clipped, force_x == ippf_pkg::SAT_POS || force_x == ippf_pkg::SAT_NEG || force_y == ippf_pkg::SAT_POS || force_y == ippf_pkg::SAT_NEG)
	`IPPF_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall)
	`IPPF_ASSERT_NEXT(a_cfg_scale, cfg_valid && cfg_ready && cfg_index == ippf_pkg::REG_FORCE_SCALE, force_scale_q == $past(cfg_data))

endmodule
